@@ design/fwm_pkg.sv @@
package fwm_pkg;

  // Command codes carried on the input channel
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control from the sequencer to the count tree
  typedef struct packed {
    logic rd_upd;  // this read is the first half of a read-modify-write
    logic inc;     // write back count + 1 (else count - 1)
  } tree_ctl_t;

endpackage

@@ design/fwm_in_if.sv @@
interface fwm_in_if #(
  parameter int VALUE_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [VALUE_BITS-1:0] value_in;

  modport source (output valid, output mode, output value_in, input ready);
  modport sink   (input valid, input mode, input value_in, output ready);
endinterface

@@ design/fwm_out_if.sv @@
interface fwm_out_if #(
  parameter int VALUE_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] median_out;
  logic [1:0]            status;

  modport source (output valid, output median_out, output status, input ready);
  modport sink   (input valid, input median_out, input status, output ready);
endinterface

@@ design/fwm_count_tree.sv @@
module fwm_count_tree #(
  parameter int VALUE_BITS = 10,
  parameter int CNT_W      = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [VALUE_BITS:0]     rd_addr,
  input  fwm_pkg::tree_ctl_t      ctl,
  output logic [CNT_W-1:0]        rd_data,
  output logic                    busy
);

  localparam int AW    = VALUE_BITS + 1;
  localparam int DEPTH = 1 << AW;

  logic [CNT_W-1:0] tree_mem [DEPTH];
  logic [CNT_W-1:0] rd_data_r;
  logic [AW-1:0]    clr_addr_r;
  logic             busy_r;
  logic             wb_r;
  logic [AW-1:0]    wb_addr_r;
  logic             wb_inc_r;
  logic [CNT_W-1:0] wb_data;

  // clearing sweep after reset, one node per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (&clr_addr_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  // write-back of an update happens in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= 1'b0;
    end else begin
      wb_r <= ctl.rd_upd & ~busy_r;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= rd_addr;
    wb_inc_r  <= ctl.inc;
  end

  // step on the count just read; a decrement stops at zero
  always_comb begin
    if (wb_inc_r) begin
      wb_data = rd_data_r + CNT_W'(1);
    end else if (rd_data_r != '0) begin
      wb_data = rd_data_r - CNT_W'(1);
    end else begin
      wb_data = rd_data_r;
    end
  end

  // count memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (busy_r) begin
      tree_mem[clr_addr_r] <= '0;
    end else if (wb_r) begin
      tree_mem[wb_addr_r] <= wb_data;
    end
    rd_data_r <= tree_mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

@@ design/fifo_window_median_top.sv @@
// FIFO of values with upper-median query.
// Input channel in_chan (valid/ready): mode selects push of value_in, pop of
// the oldest value, or median query. Output channel out_chan (valid/ready):
// one transaction per input transaction, carrying median_out and status
// (ok, empty on pop/query with nothing stored, full on push at FIFO_DEPTH).
// Median is the (count/2+1)-th smallest stored value.
// Timing: the stored multiset is a count tree held in one memory. Push and
// pop walk it root to leaf, one value bit per cycle, read-modify-write per
// level; a query first fetches the root's left count, then descends one bit
// per cycle. Error results and the unused mode skip the tree. Each result
// waits in the completion state until the output register is free, is
// registered there, and the next transaction is taken back in idle.
// Reset: pointers and count clear at once; the count tree's 2^(VALUE_BITS+1)
// nodes (2048 by default) are then cleared one node per cycle, while
// in_chan.ready stays low.
// Stall: a finished result waits in the output register; one further item
// is accepted and worked on, and its result holds until the register frees.
module fifo_window_median_top #(
  parameter int VALUE_BITS = 10,
  parameter int FIFO_DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  fwm_in_if.sink   in_chan,
  fwm_out_if.source out_chan
);

  localparam int AW    = VALUE_BITS + 1;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int LVL_W = $clog2(VALUE_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_QRY  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [VALUE_BITS-1:0]  val_sh_r, val_sh_nxt;
  logic [AW-1:0]          node_r, node_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic [LVL_W-1:0]       lvl_r, lvl_nxt;
  logic                   prime_r, prime_nxt;
  logic                   inc_r, inc_nxt;
  logic [VALUE_BITS-1:0]  res_med_r, res_med_nxt;
  fwm_pkg::status_t       res_st_r, res_st_nxt;
  logic                   out_valid_r;
  logic [VALUE_BITS-1:0]  out_med_r;
  fwm_pkg::status_t       out_st_r;

  logic [VALUE_BITS-1:0]  fifo_mem [FIFO_DEPTH];
  logic [VALUE_BITS-1:0]  store_rd_r;
  logic                   push_wr;

  logic                   accept;
  logic                   out_free;
  logic                   last_lvl;
  logic [AW-1:0]          tree_addr;
  fwm_pkg::tree_ctl_t     tree_ctl;
  logic [CNT_W-1:0]       left_cnt;
  logic                   tree_busy;
  logic                   go_right;
  logic [AW-1:0]          qnode;

  fwm_count_tree #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CNT_W)
  ) u_tree (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (tree_addr),
    .ctl     (tree_ctl),
    .rd_data (left_cnt),
    .busy    (tree_busy)
  );

  assign in_chan.ready = (state_r == S_IDLE) && !tree_busy;
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign last_lvl      = (lvl_r == LVL_W'(VALUE_BITS - 1));

  // query step: go right when the rank lies beyond the left subtree
  assign go_right = (k_r > left_cnt);
  assign qnode    = {node_r[VALUE_BITS-1:0], go_right};

  // value store: write on push, oldest entry always read ahead
  always_ff @(posedge clk) begin
    if (push_wr) begin
      fifo_mem[tail_r] <= in_chan.value_in;
    end
    store_rd_r <= fifo_mem[head_r];
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    val_sh_nxt  = val_sh_r;
    node_nxt    = node_r;
    k_nxt       = k_r;
    lvl_nxt     = lvl_r;
    prime_nxt   = prime_r;
    inc_nxt     = inc_r;
    res_med_nxt = res_med_r;
    res_st_nxt  = res_st_r;
    push_wr     = 1'b0;
    tree_addr   = {node_r[VALUE_BITS-1:0], 1'b0};
    tree_ctl    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_med_nxt = '0;
          res_st_nxt  = fwm_pkg::ST_OK;
          node_nxt    = AW'(1);
          lvl_nxt     = '0;
          state_nxt   = S_DONE;
          case (in_chan.mode)
            fwm_pkg::MODE_PUSH: begin
              if (cnt_r == CNT_W'(FIFO_DEPTH)) begin
                res_st_nxt = fwm_pkg::ST_FULL;
              end else begin
                push_wr    = 1'b1;
                tail_nxt   = (tail_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
                cnt_nxt    = cnt_r + CNT_W'(1);
                val_sh_nxt = in_chan.value_in;
                inc_nxt    = 1'b1;
                state_nxt  = S_UPD;
              end
            end
            fwm_pkg::MODE_POP: begin
              if (cnt_r == '0) begin
                res_st_nxt = fwm_pkg::ST_EMPTY;
              end else begin
                head_nxt   = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
                cnt_nxt    = cnt_r - CNT_W'(1);
                val_sh_nxt = store_rd_r;
                inc_nxt    = 1'b0;
                state_nxt  = S_UPD;
              end
            end
            fwm_pkg::MODE_QUERY: begin
              if (cnt_r == '0) begin
                res_st_nxt = fwm_pkg::ST_EMPTY;
              end else begin
                k_nxt     = (cnt_r >> 1) + CNT_W'(1);
                prime_nxt = 1'b1;
                state_nxt = S_QRY;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // one tree level per cycle, value bits shifted out MSB first
      S_UPD: begin
        tree_addr    = {node_r[VALUE_BITS-1:0], val_sh_r[VALUE_BITS-1]};
        tree_ctl.rd_upd = 1'b1;
        tree_ctl.inc    = inc_r;
        node_nxt     = tree_addr;
        val_sh_nxt   = {val_sh_r[VALUE_BITS-2:0], 1'b0};
        lvl_nxt      = lvl_r + LVL_W'(1);
        if (last_lvl) begin
          state_nxt = S_DONE;
        end
      end

      // descent: first cycle fetches the root's left child
      S_QRY: begin
        if (prime_r) begin
          prime_nxt = 1'b0;
        end else begin
          node_nxt  = qnode;
          k_nxt     = go_right ? (k_r - left_cnt) : k_r;
          tree_addr = {qnode[VALUE_BITS-1:0], 1'b0};
          lvl_nxt   = lvl_r + LVL_W'(1);
          if (last_lvl) begin
            res_med_nxt = qnode[VALUE_BITS-1:0];
            state_nxt   = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      lvl_r   <= '0;
      prime_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      lvl_r   <= lvl_nxt;
      prime_r <= prime_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    val_sh_r  <= val_sh_nxt;
    node_r    <= node_nxt;
    k_r       <= k_nxt;
    inc_r     <= inc_nxt;
    res_med_r <= res_med_nxt;
    res_st_r  <= res_st_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_med_r <= res_med_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.median_out = out_med_r;
  assign out_chan.status     = out_st_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("item count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == tail_r))
    else $error("pointers disagree with empty count");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result posted outside completion");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    tree_busy |-> (!out_valid_r && (state_r == S_IDLE)))
    else $error("activity during tree clear");

endmodule

@@ test/fifo_window_median_top_tb.sv @@
// Mirrors the value FIFO and its count tree; holds the results still owed by the block
class median_book #(int VB = 10, int DEPTH = 1024);
  localparam int LEAVES = 1 << VB;

  typedef struct {
    logic [VB-1:0]    median;
    fwm_pkg::status_t status;
  } outcome_t;

  logic [VB-1:0] slots [DEPTH];
  logic [VB:0]   tree [2*LEAVES];
  int unsigned   head_slot;
  int unsigned   tail_slot;
  int unsigned   fill;
  int unsigned   mismatches;
  outcome_t      owed [$];

  function new();
    foreach (tree[i]) tree[i] = '0;
    head_slot  = 0;
    tail_slot  = 0;
    fill       = 0;
    mismatches = 0;
  endfunction

  function int unsigned stored();
    return fill;
  endfunction

  function int unsigned pending();
    return owed.size();
  endfunction

  function int unsigned next_slot(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  // one occurrence of v in or out, leaf up to root
  function void adjust(logic [VB-1:0] v, bit up);
    int unsigned node;
    node = LEAVES + v;
    while (node >= 1) begin
      if (up) begin
        tree[node] = tree[node] + 1'b1;
      end else if (tree[node] != 0) begin
        tree[node] = tree[node] - 1'b1;
      end
      node = node >> 1;
    end
  endfunction

  // descend to the (fill/2 + 1)-th smallest stored value
  function logic [VB-1:0] upper_median();
    int unsigned rank;
    int unsigned node;
    int unsigned lvl;
    rank = fill / 2 + 1;
    node = 1;
    for (lvl = 0; lvl < VB; lvl++) begin
      if (rank <= tree[2*node]) begin
        node = 2 * node;
      end else begin
        rank = rank - tree[2*node];
        node = 2 * node + 1;
      end
    end
    return VB'(node - LEAVES);
  endfunction

  // an accepted command: update the mirror and queue what the block owes
  function void take_command(logic [1:0] cmd, logic [VB-1:0] v);
    outcome_t      res;
    logic [VB-1:0] oldest;
    res.median = '0;
    res.status = fwm_pkg::ST_OK;
    case (cmd)
      fwm_pkg::MODE_PUSH: begin
        if (fill >= DEPTH) begin
          res.status = fwm_pkg::ST_FULL;
        end else begin
          slots[tail_slot] = v;
          tail_slot = next_slot(tail_slot);
          fill++;
          adjust(v, 1'b1);
        end
      end
      fwm_pkg::MODE_POP: begin
        if (fill == 0) begin
          res.status = fwm_pkg::ST_EMPTY;
        end else begin
          oldest = slots[head_slot];
          head_slot = next_slot(head_slot);
          fill--;
          adjust(oldest, 1'b0);
        end
      end
      fwm_pkg::MODE_QUERY: begin
        if (fill == 0) res.status = fwm_pkg::ST_EMPTY;
        else res.median = upper_median();
      end
      default: ; // spare code: no effect, plain ok
    endcase
    owed.insert(owed.size(), res);
  endfunction

  function void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endfunction

  // an accepted result against the oldest one owed
  function void match_result(logic [VB-1:0] med, logic [1:0] st);
    outcome_t want;
    if (owed.size() == 0) begin
      note_mismatch($sformatf("result with nothing outstanding: median %0d status %0d",
                              med, st));
      return;
    end
    want = owed.pop_front();
    if (med !== want.median || st !== want.status) begin
      note_mismatch($sformatf("median exp %0d got %0d, status exp %0d got %0d",
                              want.median, med, want.status, st));
    end
  endfunction
endclass

module fifo_window_median_top_tb;
  localparam int VALUE_BITS    = 10;
  localparam int FIFO_DEPTH    = 1024;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int LONG_HOLD     = 80;
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 100;
  localparam int SETTLE_CYCLES = 30;

  logic clk;
  logic rst_n;
  int   hold_reqs;
  int   holds_done;
  bit   tx_burst;

  median_book #(VALUE_BITS, FIFO_DEPTH) book;

  fwm_in_if  #(.VALUE_BITS(VALUE_BITS)) in_bus ();
  fwm_out_if #(.VALUE_BITS(VALUE_BITS)) out_bus ();

  fifo_window_median_top #(
    .VALUE_BITS(VALUE_BITS),
    .FIFO_DEPTH(FIFO_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  // extremes, a narrow band for duplicates, otherwise anything
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0:       return '0;
      1:       return VALUE_MAX;
      2, 3:    return VALUE_BITS'($urandom_range(0, 7));
      default: return VALUE_BITS'($urandom_range(0, VALUE_MAX));
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] junk_value();
    return VALUE_BITS'($urandom_range(0, VALUE_MAX));
  endfunction

  // offer one command; returns at the falling edge after its transaction
  task automatic send_cmd(logic [1:0] cmd, logic [VALUE_BITS-1:0] v);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid    = 1'b1;
    in_bus.mode     = cmd;
    in_bus.value_in = v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    book.take_command(cmd, v);
    @(negedge clk);
  endtask

  task automatic random_cmd(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) send_cmd(MODE_SPARE, junk_value());
    else if (r < 25) send_cmd(fwm_pkg::MODE_QUERY, junk_value());
    else if ($urandom_range(0, 99) < push_pct) send_cmd(fwm_pkg::MODE_PUSH, pick_value());
    else send_cmd(fwm_pkg::MODE_POP, junk_value());
  endtask

  // stop offering until every owed result is back
  task automatic drain_pause();
    in_bus.valid = 1'b0;
    @(negedge clk);
    while (book.pending() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int seg;
    int k;
    int push_pct;
    book            = new();
    rst_n           = 1'b0;
    hold_reqs       = 0;
    tx_burst        = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.mode     = fwm_pkg::MODE_PUSH;
    in_bus.value_in = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty cases, spare code, extremes, duplicates, back to empty
    send_cmd(fwm_pkg::MODE_QUERY, VALUE_MAX);
    send_cmd(fwm_pkg::MODE_POP, 10'h155);
    send_cmd(MODE_SPARE, VALUE_MAX);
    send_cmd(fwm_pkg::MODE_PUSH, '0);
    send_cmd(fwm_pkg::MODE_QUERY, 10'h2AA);
    send_cmd(fwm_pkg::MODE_PUSH, VALUE_MAX);
    send_cmd(fwm_pkg::MODE_QUERY, '0);
    send_cmd(fwm_pkg::MODE_PUSH, 10'h155);
    send_cmd(fwm_pkg::MODE_PUSH, 10'h2AA);
    send_cmd(fwm_pkg::MODE_QUERY, VALUE_MAX);
    send_cmd(fwm_pkg::MODE_POP, VALUE_MAX);
    send_cmd(fwm_pkg::MODE_QUERY, '0);
    send_cmd(fwm_pkg::MODE_PUSH, VALUE_MAX);
    send_cmd(fwm_pkg::MODE_QUERY, 10'h155);
    send_cmd(MODE_SPARE, 10'h2AA);
    send_cmd(fwm_pkg::MODE_POP, '0);
    send_cmd(fwm_pkg::MODE_QUERY, '0);
    send_cmd(fwm_pkg::MODE_POP, 10'h3FF);
    send_cmd(fwm_pkg::MODE_POP, '0);
    send_cmd(fwm_pkg::MODE_POP, 10'h155);
    send_cmd(fwm_pkg::MODE_POP, 10'h2AA);
    send_cmd(fwm_pkg::MODE_QUERY, VALUE_MAX);

    // random segments, each leaning towards growth or shrinkage, or balanced
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 35;
        1:       push_pct = 50;
        default: push_pct = 65;
      endcase
      if (seg == SEGMENTS / 2) drain_pause();
      for (k = 0; k < SEGMENT_ITEMS; k++) begin
        if (seg == 2 && k == 50) hold_reqs++;
        random_cmd(push_pct);
      end
    end

    // wind down
    in_bus.valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side: random stalls, some before the result shows, some after
  initial begin
    bit rx_burst;
    int gap;
    rx_burst      = 1'b0;
    holds_done    = 0;
    out_bus.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (holds_done != hold_reqs) begin
        // long hold-off so the block backs up and stalls its input
        out_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done = hold_reqs;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        gap = pick_gap(rx_burst);
        if (!rx_burst && $urandom_range(0, 1) == 1) begin
          out_bus.ready = 1'b0;
          @(posedge clk);
          while (!out_bus.valid) @(posedge clk);
          @(negedge clk);
          repeat (gap) @(negedge clk);
        end else if (gap > 0) begin
          out_bus.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_bus.ready = 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      book.match_result(out_bus.median_out, out_bus.status);
      @(negedge clk);
    end
  end

endmodule

@@ sim.f @@
design/fwm_pkg.sv
design/fwm_in_if.sv
design/fwm_out_if.sv
design/fwm_count_tree.sv
design/fifo_window_median_top.sv
test/fifo_window_median_top_tb.sv
